### sv/tpsr_pkg.sv
// Package for the transport-stream PSI section reassembler.
// Holds constants, the parse-phase codes, the result record type and the CRC step.
// Depends on nothing.
package tpsr_pkg;

   localparam int PACKET_BYTES_DEF = 188;
   localparam logic [7:0]  SYNC_VALUE = 8'h47;
   localparam logic [31:0] CRC_POLY   = 32'h04c11db7;
   localparam logic [31:0] CRC_INIT   = 32'hffffffff;
   localparam logic [15:0] LIMIT_RESET = 16'd2000;
   localparam int FIFO_DEPTH = 4;

   localparam logic [1:0] CSR_PID   = 2'd0;
   localparam logic [1:0] CSR_TABLE = 2'd1;
   localparam logic [1:0] CSR_LIMIT = 2'd2;

   localparam logic [1:0] KIND_BODY    = 2'd0;
   localparam logic [1:0] KIND_DISCARD = 2'd1;
   localparam logic [1:0] KIND_STATUS  = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NONE     = 3'd1;
   localparam logic [2:0] ST_SMALL    = 3'd2;
   localparam logic [2:0] ST_CRC      = 3'd3;
   localparam logic [2:0] ST_LOSTSYNC = 3'd4;

   typedef enum logic [7:0] {
      PH_HDR     = 8'b0000_0001,
      PH_AFLEN   = 8'b0000_0010,
      PH_AFSKIP  = 8'b0000_0100,
      PH_PTR     = 8'b0000_1000,
      PH_PTRSKIP = 8'b0001_0000,
      PH_THDR    = 8'b0010_0000,
      PH_BODY    = 8'b0100_0000,
      PH_IGNORE  = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] body_byte;
      logic [2:0] status;
      logic       last;
   } rsp_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {b, 24'd0};
      for (int i = 0; i < 8; i++) begin
         c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
      end
      return c;
   endfunction

endpackage

### sv/ts_psi_section_reassembler.sv
// Transport-stream PSI section reassembler with CRC-32/MPEG-2 check.
// Results pass through the result queue to the rsp_ ports.
// Throughput: one byte per cycle while full is low; the parser adds no limit.
// full rises only when the result queue holds its depth entries.
// Reset (synchronous, active high) resets the registers and starts a search.
module ts_psi_section_reassembler #(
   parameter int PACKET_BYTES = tpsr_pkg::PACKET_BYTES_DEF,
   parameter int QUEUE_DEPTH  = tpsr_pkg::FIFO_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_cmd,
   input  logic [7:0]  req_stream_byte,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_body_byte,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import tpsr_pkg::*;

   logic [12:0] pid_ff;
   logic [7:0]  table_ff;
   logic [15:0] limit_ff;
   logic        fifo_full, acc, p_valid;
   rsp_type     p_item, q_item;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         pid_ff <= '0; table_ff <= '0; limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PID:   pid_ff <= csr_data[12:0];
            CSR_TABLE: table_ff <= csr_data[7:0];
            CSR_LIMIT: limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign full = fifo_full;
   assign acc  = push && !fifo_full;

   tpsr_parser #(.PACKET_BYTES(PACKET_BYTES)) u_parser (
      .clock, .reset, .in_valid(acc), .in_cmd(req_cmd), .in_byte(req_stream_byte),
      .match_pid(pid_ff), .match_table(table_ff),
      .packet_limit((limit_ff == 16'd0) ? 16'd1 : limit_ff),
      .out_valid(p_valid), .out_item(p_item));

   tpsr_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock, .reset, .wr_en(p_valid), .wr_item(p_item), .full(fifo_full),
      .empty, .rd_en(pop), .rd_item(q_item));

   assign rsp_kind      = q_item.kind;
   assign rsp_body_byte = q_item.body_byte;
   assign rsp_status    = q_item.status;
   assign rsp_last      = q_item.last;
endmodule

### sv/tpsr_parser.sv
// Front part: parses transport-stream bytes and produces at most one result per item.
// Depends on tpsr_pkg.
module tpsr_parser #(
   parameter int PACKET_BYTES = tpsr_pkg::PACKET_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 in_cmd,
   input  logic [7:0]           in_byte,
   input  logic [12:0]          match_pid,
   input  logic [7:0]           match_table,
   input  logic [15:0]          packet_limit,
   output logic                 out_valid,
   output tpsr_pkg::rsp_type    out_item
);
   import tpsr_pkg::*;

   logic [7:0]  pos_ff, pos_in;
   logic [15:0] hdr_ff, hdr_in;
   logic [7:0]  skip_ff, skip_in;
   logic [4:0]  ecc_ff, ecc_in;
   logic [11:0] rem_ff, rem_in;
   logic [11:0] size_ff, size_in;
   logic        coll_ff, coll_in;
   logic [31:0] crc_ff, crc_in;
   logic [15:0] seen_ff, seen_in;
   logic        fin_ff, fin_in;
   phase_type   ph_ff, ph_in;
   logic        spk_ff, spk_in;
   logic        vp_ff, vp_in;
   logic [2:0]  verd_ff, verd_in;

   logic        emit;
   rsp_type     item;

   always_comb begin
      logic [23:0] sh;
      logic [12:0] pid;
      logic [3:0]  cc;
      logic        bad, drop;
      logic [9:0]  len;
      logic [31:0] ncrc;
      logic [11:0] nrem;
      logic [15:0] nseen;
      pos_in = pos_ff; hdr_in = hdr_ff; skip_in = skip_ff; ecc_in = ecc_ff;
      rem_in = rem_ff; size_in = size_ff; coll_in = coll_ff; crc_in = crc_ff;
      seen_in = seen_ff; fin_in = fin_ff; ph_in = ph_ff; spk_in = spk_ff;
      vp_in = vp_ff; verd_in = verd_ff;
      emit = 1'b0;
      item = '0;
      bad = 1'b0; drop = 1'b0;
      sh = {hdr_ff, in_byte};
      pid = {sh[20:16], sh[15:8]};
      cc = sh[3:0];
      len = {hdr_ff[1:0], in_byte};
      ncrc = crc_byte(crc_ff, in_byte);
      nrem = rem_ff - 12'd1;
      nseen = seen_ff + 16'd1;
      if (in_valid) begin
         if (!in_cmd) begin
            pos_in = '0; hdr_in = '0; skip_in = '0; ecc_in = 5'h10; rem_in = '0;
            size_in = '0; coll_in = 1'b0; crc_in = CRC_INIT; seen_in = '0;
            fin_in = 1'b0; ph_in = PH_HDR; spk_in = 1'b0; vp_in = 1'b0; verd_in = ST_OK;
         end else if (fin_ff) begin
         end else if (vp_ff) begin
            fin_in = 1'b1;
            emit = 1'b1;
            item = '{kind: KIND_STATUS, body_byte: 8'd0, status: verd_ff, last: 1'b1};
         end else if (pos_ff == 8'd0 && in_byte != SYNC_VALUE) begin
            fin_in = 1'b1;
            emit = 1'b1;
            item = '{kind: KIND_STATUS, body_byte: 8'd0, status: ST_LOSTSYNC, last: 1'b1};
         end else begin
            if (pos_ff == 8'd0) begin
               ph_in = PH_HDR;
               spk_in = 1'b0;
            end else begin
               unique case (ph_ff)
                  PH_HDR: begin
                     hdr_in = sh[15:0];
                     if (pos_ff == 8'd3) begin
                        ph_in = PH_IGNORE;
                        if (pid != match_pid || sh[23] || !sh[4]) begin
                        end else if (!ecc_ff[4] && {1'b0, cc} != ecc_ff) begin
                           ecc_in = {1'b0, cc + 4'd1};
                           if (coll_ff) drop = 1'b1;
                        end else begin
                           ecc_in = {1'b0, cc + 4'd1};
                           if (sh[22] && coll_ff) drop = 1'b1;
                           else if (sh[22] || coll_ff) begin
                              spk_in = sh[22];
                              ph_in = sh[5] ? PH_AFLEN : (sh[22] ? PH_PTR : PH_BODY);
                           end
                        end
                     end
                  end
                  PH_AFLEN: begin
                     skip_in = in_byte;
                     ph_in = (in_byte != 8'd0) ? PH_AFSKIP : (spk_ff ? PH_PTR : PH_BODY);
                  end
                  PH_AFSKIP: begin
                     skip_in = skip_ff - 8'd1;
                     if (skip_ff == 8'd1) ph_in = spk_ff ? PH_PTR : PH_BODY;
                  end
                  PH_PTR: begin
                     skip_in = in_byte;
                     if (in_byte != 8'd0) ph_in = PH_PTRSKIP;
                     else begin
                        skip_in = '0; crc_in = CRC_INIT; ph_in = PH_THDR;
                     end
                  end
                  PH_PTRSKIP: begin
                     skip_in = skip_ff - 8'd1;
                     if (skip_ff == 8'd1) begin
                        crc_in = CRC_INIT; ph_in = PH_THDR;
                     end
                  end
                  PH_THDR: begin
                     crc_in = ncrc;
                     hdr_in = sh[15:0];
                     skip_in = skip_ff + 8'd1;
                     case (skip_ff)
                        8'd0: bad = (in_byte != match_table);
                        8'd1: bad = ((in_byte & 8'hfc) != 8'hb0);
                        8'd2: begin
                           if (len < 10'd5) bad = 1'b1;
                           else begin
                              size_in = {2'b00, len - 10'd5};
                              rem_in = {2'b00, len - 10'd5};
                           end
                        end
                        8'd5: bad = ((in_byte & 8'hc0) != 8'hc0);
                        8'd7: begin
                           if (size_ff == 12'd0) begin
                              coll_in = 1'b0; rem_in = '0; size_in = '0;
                              crc_in = CRC_INIT; spk_in = 1'b0; ph_in = PH_IGNORE;
                           end else begin
                              coll_in = 1'b1; spk_in = 1'b0; ph_in = PH_BODY;
                           end
                        end
                        default: ;
                     endcase
                     if (bad) drop = 1'b1;
                  end
                  PH_BODY: begin
                     if (coll_ff && rem_ff != 12'd0) begin
                        emit = 1'b1;
                        item = '{kind: KIND_BODY, body_byte: in_byte, status: ST_OK,
                                 last: 1'b0};
                        crc_in = ncrc;
                        rem_in = nrem;
                        if (nrem == 12'd0) begin
                           coll_in = 1'b0;
                           vp_in = 1'b1;
                           ph_in = PH_IGNORE;
                           if (size_ff < 12'd4) verd_in = ST_SMALL;
                           else if (ncrc != 32'd0) verd_in = ST_CRC;
                           else verd_in = ST_OK;
                        end
                     end
                  end
                  PH_IGNORE: ;
                  default: ;
               endcase
            end
            // Header parsing still open at the end of a start packet is a fault.
            if (32'(pos_ff) + 32'd1 >= 32'(PACKET_BYTES) && spk_in &&
                (ph_in == PH_AFLEN || ph_in == PH_AFSKIP || ph_in == PH_PTR ||
                 ph_in == PH_PTRSKIP || ph_in == PH_THDR))
               drop = 1'b1;
            if (drop) begin
               coll_in = 1'b0; rem_in = '0; size_in = '0; crc_in = CRC_INIT;
               spk_in = 1'b0; ph_in = PH_IGNORE;
               emit = 1'b1;
               item = '{kind: KIND_DISCARD, body_byte: 8'd0, status: ST_OK, last: 1'b0};
            end
            if (32'(pos_ff) + 32'd1 >= 32'(PACKET_BYTES)) begin
               seen_in = nseen;
               pos_in = '0;
               if (!vp_in && nseen >= packet_limit) begin
                  fin_in = 1'b1;
                  emit = 1'b1;
                  item = '{kind: KIND_STATUS, body_byte: 8'd0, status: ST_NONE,
                           last: 1'b1};
               end
            end else begin
               pos_in = pos_ff + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; hdr_ff <= '0; skip_ff <= '0; ecc_ff <= 5'h10; rem_ff <= '0;
         size_ff <= '0; coll_ff <= 1'b0; crc_ff <= CRC_INIT; seen_ff <= '0;
         fin_ff <= 1'b0; ph_ff <= PH_HDR; spk_ff <= 1'b0; vp_ff <= 1'b0;
         verd_ff <= ST_OK;
      end else begin
         pos_ff <= pos_in; hdr_ff <= hdr_in; skip_ff <= skip_in; ecc_ff <= ecc_in;
         rem_ff <= rem_in; size_ff <= size_in; coll_ff <= coll_in; crc_ff <= crc_in;
         seen_ff <= seen_in; fin_ff <= fin_in; ph_ff <= ph_in; spk_ff <= spk_in;
         vp_ff <= vp_in; verd_ff <= verd_in;
      end
   end

   assign out_valid = emit;
   assign out_item  = item;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) < PACKET_BYTES) else $error("byte position out of range");
   a_fin_quiet: assert property (@(posedge clock) disable iff (reset)
      fin_ff && in_valid && in_cmd |-> !emit) else $error("item after end");
   a_verdict_next: assert property (@(posedge clock) disable iff (reset)
      vp_ff && !fin_ff && in_valid && in_cmd |-> emit && item.kind == KIND_STATUS)
      else $error("verdict not delivered");
   a_body_coll: assert property (@(posedge clock) disable iff (reset)
      emit && item.kind == KIND_BODY |-> coll_ff) else $error("body byte while idle");
endmodule

### sv/tpsr_fifo.sv
// Back part: result queue between the parser and the result port.
// Depends on tpsr_pkg.
module tpsr_fifo #(
   parameter int DEPTH = tpsr_pkg::FIFO_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  tpsr_pkg::rsp_type wr_item,
   output logic              full,
   output logic              empty,
   input  logic              rd_en,
   output tpsr_pkg::rsp_type rd_item
);
   import tpsr_pkg::*;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   rsp_type      mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          do_wr, do_rd;

   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;
   assign full  = (cnt_ff == (AW+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign rd_item = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff; rp_in = rp_ff;
      if (do_wr) wp_in = (32'(wp_ff) == DEPTH-1) ? '0 : wp_ff + 1'b1;
      if (do_rd) rp_in = (32'(rp_ff) == DEPTH-1) ? '0 : rp_ff + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(do_wr) - (AW+1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wp_ff] <= wr_item;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH)) else $error("queue overflow");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      do_wr && !do_rd |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("count slip");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      empty |-> wp_ff == rp_ff) else $error("pointer mismatch");
endmodule

### tb/tb_ts_psi_section_reassembler.sv
// Testbench for the transport-stream PSI section reassembler.
// Builds packets and sections, predicts every result item and compares them in order.
// Depends on tpsr_pkg and ts_psi_section_reassembler.
`timescale 1ns / 100ps

module tb_ts_psi_section_reassembler;
   import tpsr_pkg::*;

   localparam int PKT = 188;
   localparam longint CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_cmd = 1'b0;
   logic [7:0]  req_stream_byte = 8'd0;
   logic        empty;
   logic        pop = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_body_byte;
   logic [2:0]  rsp_status;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [15:0] csr_data = 16'd0;

   ts_psi_section_reassembler uut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_cmd(req_cmd), .req_stream_byte(req_stream_byte),
      .empty(empty), .pop(pop), .rsp_kind(rsp_kind), .rsp_body_byte(rsp_body_byte),
      .rsp_status(rsp_status), .rsp_last(rsp_last), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor copy of the configuration and of the parser state.
   logic [12:0] m_pid;
   logic [7:0]  m_table;
   logic [15:0] m_limit;
   int unsigned m_pos;
   logic [31:0] m_shadow;
   logic [7:0]  m_skip;
   logic [4:0]  m_cc;
   logic [11:0] m_remain, m_size;
   logic        m_collect;
   logic [31:0] m_crc;
   logic [15:0] m_pkts;
   logic        m_done, m_start, m_pending;
   logic [2:0]  m_verdict;
   phase_type   m_phase;

   rsp_type expected_items[$];
   int errors = 0;
   longint cycles = 0;
   int pop_wait = 0;

   task automatic clear_search();
      m_pos = 0; m_shadow = '0; m_skip = '0; m_cc = 5'h10;
      m_remain = '0; m_size = '0; m_collect = 1'b0; m_crc = CRC_INIT;
      m_pkts = '0; m_done = 1'b0; m_phase = PH_HDR; m_start = 1'b0;
      m_pending = 1'b0; m_verdict = ST_OK;
   endtask

   function automatic logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c ^ {b, 24'd0};
      for (int i = 0; i < 8; i++)
         r = r[31] ? ({r[30:0], 1'b0} ^ 32'h04c11db7) : {r[30:0], 1'b0};
      return r;
   endfunction

   task automatic drop_section();
      m_collect = 1'b0; m_remain = '0; m_size = '0; m_crc = CRC_INIT;
      m_start = 1'b0; m_phase = PH_IGNORE;
   endtask

   task automatic add_expect(logic [1:0] k, logic [7:0] b, logic [2:0] s);
      rsp_type r;
      r.kind = k; r.body_byte = b; r.status = s; r.last = (k == KIND_STATUS);
      expected_items.push_back(r);
   endtask

   task automatic predict_section_byte(logic cmd, logic [7:0] b);
      int unsigned pos;
      int kind;
      logic [7:0] body, b1, b2, b3, idx;
      logic [12:0] pid;
      logic [9:0] len;
      logic bad;
      pos = m_pos; kind = -1; body = 8'd0; bad = 1'b0;
      if (!cmd) begin
         clear_search();
         return;
      end
      if (m_done) return;
      if (m_pending) begin
         m_done = 1'b1;
         add_expect(KIND_STATUS, 8'd0, m_verdict);
         return;
      end
      if (pos == 0) begin
         if (b != SYNC_VALUE) begin
            m_done = 1'b1;
            add_expect(KIND_STATUS, 8'd0, ST_LOSTSYNC);
            return;
         end
         m_phase = PH_HDR; m_start = 1'b0;
      end else begin
         case (m_phase)
            PH_HDR: begin
               m_shadow = {m_shadow[23:0], b};
               if (pos == 3) begin
                  b1 = m_shadow[23:16]; b2 = m_shadow[15:8]; b3 = m_shadow[7:0];
                  pid = {b1[4:0], b2};
                  m_phase = PH_IGNORE;
                  if (pid != m_pid || b1[7] || !b3[4]) begin
                  end else if (!m_cc[4] && b3[3:0] != m_cc[3:0]) begin
                     m_cc = {1'b0, b3[3:0] + 4'd1};
                     if (m_collect) begin
                        drop_section(); kind = KIND_DISCARD;
                     end
                  end else begin
                     m_cc = {1'b0, b3[3:0] + 4'd1};
                     if (b1[6] && m_collect) begin
                        drop_section(); kind = KIND_DISCARD;
                     end else if (b1[6] || m_collect) begin
                        m_start = b1[6];
                        m_phase = b3[5] ? PH_AFLEN : (m_start ? PH_PTR : PH_BODY);
                     end
                  end
               end
            end
            PH_AFLEN: begin
               m_skip = b;
               m_phase = (b != 0) ? PH_AFSKIP : (m_start ? PH_PTR : PH_BODY);
            end
            PH_AFSKIP: begin
               m_skip = m_skip - 8'd1;
               if (m_skip == 0) m_phase = m_start ? PH_PTR : PH_BODY;
            end
            PH_PTR, PH_PTRSKIP: begin
               if (m_phase == PH_PTR) m_skip = b;
               else m_skip = m_skip - 8'd1;
               if (m_phase == PH_PTR && b != 0) m_phase = PH_PTRSKIP;
               else if (m_skip == 0) begin
                  m_skip = '0; m_crc = CRC_INIT; m_phase = PH_THDR;
               end
            end
            PH_THDR: begin
               idx = m_skip;
               m_crc = crc_next(m_crc, b);
               m_shadow = {m_shadow[23:0], b};
               m_skip = m_skip + 8'd1;
               if (idx == 0) bad = (b != m_table);
               else if (idx == 1) bad = ((b & 8'hfc) != 8'hb0);
               else if (idx == 2) begin
                  len = {m_shadow[9:8], b};
                  if (len < 5) bad = 1'b1;
                  else begin
                     m_size = len - 12'd5; m_remain = m_size;
                  end
               end else if (idx == 5) bad = ((b & 8'hc0) != 8'hc0);
               else if (idx == 7) begin
                  if (m_size == 0) drop_section();
                  else begin
                     m_collect = 1'b1; m_start = 1'b0; m_phase = PH_BODY;
                  end
               end
               if (bad) begin
                  drop_section(); kind = KIND_DISCARD;
               end
            end
            PH_BODY: begin
               if (m_collect && m_remain != 0) begin
                  kind = KIND_BODY; body = b;
                  m_crc = crc_next(m_crc, b);
                  m_remain = m_remain - 12'd1;
                  if (m_remain == 0) begin
                     m_collect = 1'b0;
                     if (m_size < 4) m_verdict = ST_SMALL;
                     else if (m_crc != 0) m_verdict = ST_CRC;
                     else m_verdict = ST_OK;
                     m_pending = 1'b1; m_phase = PH_IGNORE;
                  end
               end
            end
            default: ;
         endcase
      end
      if (pos + 1 >= PKT) begin
         if (m_start && m_phase inside {PH_AFLEN, PH_AFSKIP, PH_PTR, PH_PTRSKIP, PH_THDR})
         begin
            drop_section(); kind = KIND_DISCARD;
         end
         m_pkts = m_pkts + 16'd1;
         m_pos = 0;
         if (!m_pending && m_pkts >= ((m_limit == 0) ? 16'd1 : m_limit)) begin
            m_done = 1'b1;
            add_expect(KIND_STATUS, 8'd0, ST_NONE);
            return;
         end
      end else m_pos = pos + 1;
      if (kind >= 0) add_expect(kind[1:0], body, ST_OK);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
   endtask

   // Sends one item after a random gap; the prediction runs at acceptance.
   // push stays high after acceptance until the next item or a drain lowers it.
   task automatic send_item(logic cmd, logic [7:0] b, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1; req_cmd <= cmd; req_stream_byte <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_section_byte(cmd, b);
   endtask

   task automatic drain();
      push <= 1'b0;
      while (expected_items.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_PID:   m_pid = val[12:0];
         CSR_TABLE: m_table = val[7:0];
         CSR_LIMIT: m_limit = val;
         default: ;
      endcase
   endtask

   // Result side: a random wait before each item, compare each accepted item.
   always @(posedge clock) begin
      rsp_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_ts_psi_section_reassembler: done, errors");
         $finish;
      end
      if (!reset && pop && !empty) begin
         if (expected_items.size() == 0) report_mismatch("unexpected item", rsp_kind, -1);
         else begin
            want = expected_items.pop_front();
            if (rsp_kind != want.kind) report_mismatch("kind", rsp_kind, want.kind);
            if (rsp_body_byte != want.body_byte)
               report_mismatch("body_byte", rsp_body_byte, want.body_byte);
            if (rsp_status != want.status) report_mismatch("status", rsp_status, want.status);
            if (rsp_last != want.last) report_mismatch("last", rsp_last, want.last);
         end
         pop_wait = $urandom_range(0, 6);
      end else if (pop_wait > 0) pop_wait--;
      pop <= (pop_wait == 0);
   end

   // Builds one packet from the given header fields and payload content.
   task automatic send_packet(logic [12:0] pid, logic pusi, logic [3:0] cc, logic af,
                              logic [7:0] af_len, logic [7:0] payload[$], bit tei = 0);
      logic [7:0] pkt[PKT];
      int n;
      pkt[0] = SYNC_VALUE;
      pkt[1] = {tei, pusi, 1'b0, pid[12:8]};
      pkt[2] = pid[7:0];
      pkt[3] = {2'b00, af, 1'b1, cc};
      n = 4;
      if (af) begin
         pkt[n++] = af_len;
         for (int i = 0; i < af_len && n < PKT; i++) pkt[n++] = 8'($urandom_range(0, 255));
      end
      foreach (payload[i]) if (n < PKT) pkt[n++] = payload[i];
      while (n < PKT) pkt[n++] = 8'hff;
      for (int i = 0; i < PKT; i++) send_item(1'b1, pkt[i]);
   endtask

   // Payload of a start packet: pointer, long header, body with a valid or broken CRC.
   function automatic void make_section(ref logic [7:0] p[$], input logic [7:0] tid,
                                        input int body_len, input bit good_crc,
                                        input logic [7:0] ptr = 0);
      logic [31:0] c;
      int len;
      logic [7:0] sec[$];
      len = body_len + 5;
      sec = {tid, 8'hb0 | 8'(len >> 8), 8'(len), 8'h12, 8'h34, 8'hc1, 8'h00, 8'h00};
      for (int i = 0; i < body_len - 4; i++) sec.push_back(8'($urandom_range(0, 255)));
      c = CRC_INIT;
      foreach (sec[i]) c = crc_next(c, sec[i]);
      if (!good_crc) c = c ^ 32'h1;
      if (body_len >= 4) sec = {sec, c[31:24], c[23:16], c[15:8], c[7:0]};
      else for (int i = 0; i < body_len; i++) sec.push_back(8'($urandom_range(0, 255)));
      p = {};
      p.push_back(ptr);
      for (int i = 0; i < ptr; i++) p.push_back(8'($urandom_range(0, 255)));
      p = {p, sec};
   endfunction

   task automatic new_search();
      send_item(1'b0, 8'($urandom_range(0, 255)));
   endtask

   // A good section, then a too-small one behind a pointer field.
   task automatic test_good_sections();
      logic [7:0] p[$];
      new_search();
      make_section(p, m_table, 20, 1);
      send_packet(m_pid, 1, 4'd3, 1, 8'd3, p);
      send_item(1'b1, 8'h00);
      new_search();
      make_section(p, m_table, 2, 1, 8'd2);
      send_packet(m_pid, 1, 4'd15, 1, 8'd0, p);
      send_item(1'b1, 8'h5a);
      send_item(1'b1, 8'h47);
      drain();
   endtask

   // Wrong table, empty section, header cut off by the packet end, stray
   // continuation and finally a broken sync byte.
   task automatic test_faults();
      logic [7:0] p[$];
      new_search();
      make_section(p, m_table ^ 8'h01, 8, 1);
      send_packet(m_pid, 1, 4'd1, 0, 0, p);
      make_section(p, m_table, 0, 1);
      send_packet(m_pid, 1, 4'd2, 0, 0, p);
      make_section(p, m_table, 8, 1);
      send_packet(m_pid, 1, 4'd3, 1, 8'd183, p);
      send_packet(m_pid, 0, 4'd4, 0, 0, p);
      send_item(1'b1, 8'h46);
      send_item(1'b1, 8'h47);
      drain();
   endtask

   // Continuity break, unexpected start and a section spread over two packets.
   task automatic test_multi_packet();
      logic [7:0] p[$];
      new_search();
      make_section(p, m_table, 300, 1);
      send_packet(m_pid, 1, 4'd7, 0, 0, p);
      p = p[184:$];
      send_packet(m_pid, 0, 4'd9, 0, 0, p);
      make_section(p, m_table, 300, 1);
      send_packet(m_pid, 1, 4'd10, 0, 0, p);
      send_packet(m_pid, 1, 4'd11, 0, 0, p);
      make_section(p, m_table, 300, 0);
      send_packet(m_pid, 1, 4'd12, 0, 0, p);
      p = p[184:$];
      send_packet(m_pid, 0, 4'd13, 1, 8'd4, p);
      send_item(1'b1, 8'h00);
      drain();
   endtask

   // A limit of zero ends the search after one packet with a partial section.
   task automatic test_limit_floor();
      logic [7:0] p[$];
      new_search();
      make_section(p, m_table, 300, 1);
      send_packet(m_pid, 1, 4'd6, 0, 0, p);
      send_item(1'b1, 8'h47);
      drain();
   endtask

   initial begin
      clear_search();
      m_pid = '0; m_table = '0; m_limit = LIMIT_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_good_sections();
      write_reg(CSR_PID, 16'h1fff);
      write_reg(CSR_TABLE, 16'h00ff);
      write_reg(CSR_LIMIT, 16'hffff);
      test_faults();
      test_multi_packet();
      write_reg(CSR_PID, 16'h0a5a);
      write_reg(CSR_TABLE, 16'h0042);
      write_reg(CSR_LIMIT, 16'd0);
      test_limit_floor();
      drain();
      if (errors == 0 && expected_items.size() == 0)
         $display("tb_ts_psi_section_reassembler: done, clean");
      else
         $display("tb_ts_psi_section_reassembler: done, errors");
      $finish;
   end
endmodule
